>>> src/npt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and codes for the nearest point table.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic no_scan;
    logic last_issue;
    logic pipe_idle;
  } status_t;

endpackage

>>> src/npt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer: captures an item, runs the table scan unless none is needed, then retires the item.
// ----------------------------------------------------------------------------
module npt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  npt_pkg::status_t stat,
  output npt_pkg::cmd_t    cmd,
  output logic             busy
);

  npt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npt_pkg::S_IDLE: begin
        if (start) state_nxt = npt_pkg::S_CHECK;
      end
      npt_pkg::S_CHECK: begin
        state_nxt = stat.no_scan ? npt_pkg::S_FINISH : npt_pkg::S_SCAN;
      end
      npt_pkg::S_SCAN: begin
        if (stat.last_issue) state_nxt = npt_pkg::S_DRAIN;
      end
      npt_pkg::S_DRAIN: begin
        if (stat.pipe_idle) state_nxt = npt_pkg::S_FINISH;
      end
      npt_pkg::S_FINISH: begin
        state_nxt = npt_pkg::S_IDLE;
      end
      default: state_nxt = npt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      npt_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      npt_pkg::S_SCAN:   cmd.issue  = 1'b1;
      npt_pkg::S_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/npt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_datapath
// Entry memory, scan pipeline (read, square, accumulate) and result registers.
// ----------------------------------------------------------------------------
module npt_datapath #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  npt_pkg::cmd_t     cmd,
  output npt_pkg::status_t  stat,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_entry_id,
  input  logic [15:0]       in_point_x,
  input  logic [15:0]       in_point_y,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [15:0]       out_found_id,
  output logic [15:0]       out_found_x,
  output logic [15:0]       out_found_y,
  output logic [32:0]       out_distance_sq,
  output logic [6:0]        out_entry_count
);

  localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int SW   = 2 * CW;
  localparam int DW   = SW + 1;
  localparam int EW   = 16 + SW;
  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);

  logic [EW-1:0] mem [MAX_ENTRIES];

  logic [1:0]    req_mode_r;
  logic [15:0]   req_key_r;
  logic [CW-1:0] req_x_r, req_y_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_idx_r;

  logic          v1_r, v2_r;
  logic [EW-1:0] rd_r;

  logic [15:0]   s2_key_r;
  logic [CW-1:0] s2_x_r, s2_y_r;
  logic [SW-1:0] sq_x_r, sq_y_r;

  logic          best_valid_r;
  logic [15:0]   best_key_r;
  logic [CW-1:0] best_x_r, best_y_r;
  logic [DW-1:0] best_d_r;

  logic [15:0]   rd_key;
  logic [CW-1:0] rd_x, rd_y, dx, dy;
  logic [SW-1:0] dx_w, dy_w;
  logic [DW-1:0] cand_d;
  logic          better, key_eq, upd;
  logic          ins_ok;

  logic [1:0]    res_status;
  logic          res_hit;
  logic          res_dist;

  assign rd_key = rd_r[EW-1 -: 16];
  assign rd_x   = rd_r[SW-1 -: CW];
  assign rd_y   = rd_r[CW-1:0];

  assign dx   = (req_x_r >= rd_x) ? (req_x_r - rd_x) : (rd_x - req_x_r);
  assign dy   = (req_y_r >= rd_y) ? (req_y_r - rd_y) : (rd_y - req_y_r);
  assign dx_w = SW'(dx);
  assign dy_w = SW'(dy);

  assign cand_d = DW'(sq_x_r) + DW'(sq_y_r);
  assign better = !best_valid_r || (cand_d < best_d_r) ||
                  ((cand_d == best_d_r) && (s2_key_r < best_key_r));
  assign key_eq = (s2_key_r == req_key_r);
  assign upd    = v2_r && ((req_mode_r == npt_pkg::MODE_NEAREST) ? better : key_eq);

  assign stat.no_scan    = (count_r == '0) ||
                           ((req_mode_r != npt_pkg::MODE_INSERT) &&
                            (req_mode_r != npt_pkg::MODE_NEAREST) &&
                            (req_mode_r != npt_pkg::MODE_LOOKUP));
  assign stat.last_issue = ((CNTW'(scan_idx_r) + CNTW'(1)) == count_r);
  assign stat.pipe_idle  = !v1_r && !v2_r;

  // request capture and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_key_r  <= in_entry_id;
      req_x_r    <= in_point_x[CW-1:0];
      req_y_r    <= in_point_y[CW-1:0];
      scan_idx_r <= '0;
    end else if (cmd.issue) begin
      scan_idx_r <= scan_idx_r + AW'(1);
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.finish && ins_ok) begin
      mem[count_r[AW-1:0]] <= {req_key_r, req_x_r, req_y_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_r <= mem[scan_idx_r];
    end
  end

  // square stage
  always_ff @(posedge clk) begin
    if (v1_r) begin
      s2_key_r <= rd_key;
      s2_x_r   <= rd_x;
      s2_y_r   <= rd_y;
      sq_x_r   <= dx_w * dx_w;
      sq_y_r   <= dy_w * dy_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.load) begin
      best_valid_r <= 1'b0;
    end else if (upd) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      best_key_r <= s2_key_r;
      best_x_r   <= s2_x_r;
      best_y_r   <= s2_y_r;
      best_d_r   <= cand_d;
    end
  end

  // retire
  always_comb begin
    ins_ok     = 1'b0;
    res_status = npt_pkg::ST_OK;
    res_hit    = 1'b0;
    res_dist   = 1'b0;
    count_nxt  = count_r;
    unique case (req_mode_r)
      npt_pkg::MODE_INSERT: begin
        if (best_valid_r) begin
          res_status = npt_pkg::ST_DUP;
        end else if (count_r == CNTW'(MAX_ENTRIES)) begin
          res_status = npt_pkg::ST_FULL;
        end else begin
          ins_ok    = 1'b1;
          count_nxt = count_r + CNTW'(1);
        end
      end
      npt_pkg::MODE_NEAREST: begin
        res_status = best_valid_r ? npt_pkg::ST_OK : npt_pkg::ST_MISS;
        res_hit    = best_valid_r;
        res_dist   = best_valid_r;
      end
      npt_pkg::MODE_LOOKUP: begin
        res_status = best_valid_r ? npt_pkg::ST_OK : npt_pkg::ST_MISS;
        res_hit    = best_valid_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= res_status;
      out_found_id    <= res_hit ? best_key_r : 16'd0;
      out_found_x     <= res_hit ? 16'(best_x_r) : 16'd0;
      out_found_y     <= res_hit ? 16'(best_y_r) : 16'd0;
      out_distance_sq <= res_dist ? 33'(best_d_r) : 33'd0;
      out_entry_count <= 7'(count_nxt);
    end
  end

endmodule

>>> src/nearest_point_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_table_core
// Id-keyed point table with insert, lookup and nearest-point query.
// ----------------------------------------------------------------------------
// Usage: drive in_mode, in_entry_id, in_point_x, in_point_y and raise start;
// the item is taken at a clock edge with start high and busy low. Modes:
// insert, nearest query, lookup by id. Each item yields one result, shown
// for a single cycle with out_valid high; the receiver cannot stall it.
// Entries are stored in slot order and never removed, so a scan covers the
// N filled slots. An item that scans reads one slot per cycle from the
// entry memory, then drains the three-stage read/square/accumulate pipeline
// before its result is registered in the finish state; mode three or an
// empty table skips the scan and goes from the check state to finish. busy
// falls in the strobe cycle, so the next item may be taken there.
// Reset (rst_n low, synchronous) empties the table and drops any item in
// flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_point_table_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_entry_id,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_found_id,
  output logic [15:0] out_found_x,
  output logic [15:0] out_found_y,
  output logic [32:0] out_distance_sq,
  output logic [6:0]  out_entry_count
);

  npt_pkg::cmd_t    cmd;
  npt_pkg::status_t stat;

  npt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  npt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_entry_id     (in_entry_id),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_id    (out_found_id),
    .out_found_x     (out_found_x),
    .out_found_y     (out_found_y),
    .out_distance_sq (out_distance_sq),
    .out_entry_count (out_entry_count)
  );

endmodule
